FILE: hw/rtl/cpsb_pkg.sv
// Package for the clipped pixel stream blitter.
// Holds widths, register indexes, pixel order codes and the shared structs.
// No dependencies.
package cpsb_pkg;

  localparam int COORD_BITS = 16;
  localparam int ADDR_BITS  = 26;

  localparam int NUM_REGS        = 8;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);

  localparam int BYTE_W     = 8;
  localparam int IMG_W      = 16;
  localparam int TOP_W      = 21;
  localparam int DISP_W     = 13;
  localparam int POS_W      = DISP_W - 1;
  localparam int STRIDE_W   = 15;
  localparam int ORDER_W    = 2;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_DATA_W = TOP_W;

  localparam int CMP_W  = (COORD_BITS > IMG_W) ? COORD_BITS : IMG_W;
  localparam int DX_W   = CMP_W + 1;
  localparam int DY_W   = ((CMP_W + 1 > TOP_W) ? CMP_W + 1 : TOP_W) + 1;
  localparam int PROD_W = POS_W + STRIDE_W;
  localparam int SUM_W  = (PROD_W + 1 > ADDR_BITS) ? PROD_W + 1 : ADDR_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_OFFSET     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X       = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ORDER    = CFG_IDX_W'(7);

  localparam logic [ORDER_W-1:0] ORDER_NONE = ORDER_W'(0);
  localparam logic [ORDER_W-1:0] ORDER_RGB  = ORDER_W'(1);
  localparam logic [ORDER_W-1:0] ORDER_BGR  = ORDER_W'(2);

  typedef struct packed {
    logic [IMG_W-1:0]    image_width;
    logic [IMG_W-1:0]    image_height;
    logic [TOP_W-1:0]    top_offset;
    logic [IMG_W-1:0]    scroll_x;
    logic [DISP_W-1:0]   display_width;
    logic [DISP_W-1:0]   display_height;
    logic [STRIDE_W-1:0] line_stride;
    logic [ORDER_W-1:0]  pixel_order;
  } cfg_t;

  typedef struct packed {
    logic              write_enable;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [BYTE_W-1:0] byte2;
  } blit_job_t;

endpackage

FILE: hw/rtl/cpsb_if.sv
// Channel interfaces of the clipped pixel stream blitter.
// cpsb_pixel_if carries input pixels, cpsb_write_if carries framebuffer writes.
// Depends on cpsb_pkg.
interface cpsb_pixel_if;
  import cpsb_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_of_image;
  logic [BYTE_W-1:0] chan0_high;
  logic [BYTE_W-1:0] chan1_high;
  logic [BYTE_W-1:0] chan2_high;

  modport source (output valid, start_of_image, chan0_high, chan1_high, chan2_high,
                  input ready);
  modport sink (input valid, start_of_image, chan0_high, chan1_high, chan2_high,
                output ready);
endinterface

interface cpsb_write_if;
  import cpsb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 write_enable;
  logic [ADDR_BITS-1:0] byte_address;
  logic [BYTE_W-1:0]    out_byte0;
  logic [BYTE_W-1:0]    out_byte1;
  logic [BYTE_W-1:0]    out_byte2;

  modport source (output valid, write_enable, byte_address, out_byte0, out_byte1, out_byte2,
                  input ready);
  modport sink (input valid, write_enable, byte_address, out_byte0, out_byte1, out_byte2,
                output ready);
endinterface

FILE: hw/rtl/clipped_pixel_stream_blitter.sv
// Clipped pixel stream blitter, top level.
// Usage:
//   in_ch  takes one pixel per request: start_of_image and the high bytes of
//          the first three channels. start_of_image restarts the raster walk.
//   out_ch gives exactly one write request per pixel: write_enable, the
//          framebuffer byte_address and three bytes in the configured order.
//          write_enable low means the pixel was clipped or the order is
//          neither RGB nor BGR; all other fields are then zero.
//   cfg_*  writes register cfg_index with cfg_wdata when cfg_we is high.
//          Write only while no pixel is in flight.
// Accepted pixels pass a queue slot and the output register before out_ch.
// Throughput: one pixel per cycle unless out_ch stalls, set by the raster
//   counter update in the front end and the single back end multiply-add.
// Reset clears the raster counters, the job queue, the out_ch valid bit and
//   loads the register defaults (image width 1, everything else zero).
// When out_ch stalls, the output register holds, the two-entry job queue
//   fills, and in_ch.ready drops once it is full.
// Depends on cpsb_pkg, cpsb_if, cpsb_front, cpsb_queue and cpsb_back.
module clipped_pixel_stream_blitter (
  input  logic                               clk,
  input  logic                               rst_n,
  cpsb_pixel_if.sink                         in_ch,
  cpsb_write_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [cpsb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cpsb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import cpsb_pkg::*;

  cfg_t      cfg_r;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;
  blit_job_t fq_job, qb_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{image_width: IMG_W'(1), default: '0};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_wdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_wdata[IMG_W-1:0];
        REG_TOP_OFFSET:     cfg_r.top_offset     <= cfg_wdata[TOP_W-1:0];
        REG_SCROLL_X:       cfg_r.scroll_x       <= cfg_wdata[IMG_W-1:0];
        REG_DISPLAY_WIDTH:  cfg_r.display_width  <= cfg_wdata[DISP_W-1:0];
        REG_DISPLAY_HEIGHT: cfg_r.display_height <= cfg_wdata[DISP_W-1:0];
        REG_LINE_STRIDE:    cfg_r.line_stride    <= cfg_wdata[STRIDE_W-1:0];
        REG_PIXEL_ORDER:    cfg_r.pixel_order    <= cfg_wdata[ORDER_W-1:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  cpsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  cpsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  cpsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/cpsb_front.sv
// Front end: accepts pixels, walks the raster counters and clips each pixel.
// Emits one classified write job per pixel into the job queue.
// Depends on cpsb_pkg and cpsb_pixel_if.
module cpsb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  cpsb_pkg::cfg_t      cfg,
  cpsb_pixel_if.sink          in_ch,
  output logic                job_valid,
  input  logic                job_ready,
  output cpsb_pkg::blit_job_t job
);
  import cpsb_pkg::*;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] col_base, row_base, col_inc;
  logic [DX_W-1:0]       dx;
  logic [DY_W-1:0]       dy;
  logic                  row_in, dx_ok, dy_ok, order_ok, visible, wrap, accept;

  assign in_ch.ready = job_ready;
  assign job_valid   = in_ch.valid;
  assign accept      = in_ch.valid && in_ch.ready;

  assign col_base = in_ch.start_of_image ? '0 : col_r;
  assign row_base = in_ch.start_of_image ? '0 : row_r;

  assign dx = DX_W'(CMP_W'(col_base)) - DX_W'(CMP_W'(cfg.scroll_x));
  assign dy = DY_W'(CMP_W'(row_base)) + DY_W'($signed(cfg.top_offset));

  assign row_in   = CMP_W'(row_base) < CMP_W'(cfg.image_height);
  assign dx_ok    = !dx[DX_W-1] && (dx < DX_W'(cfg.display_width));
  assign dy_ok    = !dy[DY_W-1] && (dy < DY_W'(cfg.display_height));
  assign order_ok = (cfg.pixel_order == ORDER_RGB) || (cfg.pixel_order == ORDER_BGR);
  assign visible  = row_in && dx_ok && dy_ok && order_ok;

  always_comb begin
    job = '0;
    if (visible) begin
      job.write_enable = 1'b1;
      job.pos_x        = dx[POS_W-1:0];
      job.pos_y        = dy[POS_W-1:0];
      job.byte1        = in_ch.chan1_high;
      if (cfg.pixel_order == ORDER_RGB) begin
        job.byte0 = in_ch.chan2_high;
        job.byte2 = in_ch.chan0_high;
      end else begin
        job.byte0 = in_ch.chan0_high;
        job.byte2 = in_ch.chan2_high;
      end
    end
  end

  assign col_inc = col_base + COORD_BITS'(1);
  assign wrap    = CMP_W'(col_inc) >= CMP_W'(cfg.image_width);

  always_comb begin
    col_nxt = col_inc;
    row_nxt = row_base;
    if (wrap) begin
      col_nxt = '0;
      if (row_in) begin
        row_nxt = row_base + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: hw/rtl/cpsb_queue.sv
// Short job queue between the front end and the back end.
// Registered storage; full blocks the front, empty idles the back.
// Depends on cpsb_pkg.
module cpsb_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  cpsb_pkg::blit_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output cpsb_pkg::blit_job_t pop_job
);
  import cpsb_pkg::*;

  blit_job_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cpsb_back.sv
// Back end: turns a write job into a framebuffer byte address and bytes.
// One multiply-add per job into the registered output stage.
// Depends on cpsb_pkg and cpsb_write_if.
module cpsb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cpsb_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_ready,
  input  cpsb_pkg::blit_job_t job,
  cpsb_write_if.source        out_ch
);
  import cpsb_pkg::*;

  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     addr_sum;
  logic                 valid_r, we_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [BYTE_W-1:0]    b0_r, b1_r, b2_r;
  logic                 load;

  assign job_ready = !valid_r || out_ch.ready;
  assign load      = job_valid && job_ready;

  assign prod     = PROD_W'(job.pos_y) * PROD_W'(cfg.line_stride);
  assign addr_sum = SUM_W'(prod) + (SUM_W'(job.pos_x) << BPP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      we_r   <= job.write_enable;
      addr_r <= addr_sum[ADDR_BITS-1:0];
      b0_r   <= job.byte0;
      b1_r   <= job.byte1;
      b2_r   <= job.byte2;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.byte_address = addr_r;
  assign out_ch.out_byte0    = b0_r;
  assign out_ch.out_byte1    = b1_r;
  assign out_ch.out_byte2    = b2_r;

endmodule
